/* rtl/trhq_pkg.sv */
// ----------------------------------------------------------------------------
// trhq_pkg
// shared types, sizes and codes of the touch region hit test queue
// ----------------------------------------------------------------------------
package trhq_pkg;

  // store sizes
  localparam int AREA_ENTRIES = 64;
  localparam int LEVEL_SLOTS  = 16;
  localparam int EVENT_SLOTS  = 16;

  // address and counter widths that follow from the store sizes
  localparam int AREA_AW  = $clog2(AREA_ENTRIES);
  localparam int LVL_AW   = $clog2(LEVEL_SLOTS);
  localparam int LVL_TW   = $clog2(LEVEL_SLOTS + 1);
  localparam int EVT_AW   = $clog2(EVENT_SLOTS);

  // request and result field widths
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int COORD_W  = 10;
  localparam int EVT_W    = 8;
  localparam int STAT_W   = 8;
  localparam int CODE_W   = 3;
  localparam int QCNT_W   = 4;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_AREA = 3'd0,
    CMD_PUSH_LEVEL = 3'd1,
    CMD_POP_LEVEL  = 3'd2,
    CMD_TOUCH      = 3'd3,
    CMD_POP_EVENT  = 3'd4
  } cmd_t;

  // result codes
  typedef enum logic [CODE_W-1:0] {
    RES_OK          = 3'd0,
    RES_STACK_FULL  = 3'd1,
    RES_POP_BAD     = 3'd2,
    RES_NO_LEVEL    = 3'd3,
    RES_QUEUE_EMPTY = 3'd4,
    RES_BAD_RANGE   = 3'd5
  } res_code_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  // one touch rectangle, 49 bits
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic               flag;
    logic [EVT_W-1:0]   event_code;
  } area_t;

  // one level of the stack
  typedef struct packed {
    logic [IDX_W-1:0] base;
    logic [CNT_W-1:0] size;
  } lvl_entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    lvl_entry_t entry;
  } lvl_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    lvl_entry_t top_entry;
  } lvl_stat_t;

  // one queued event
  typedef struct packed {
    logic [EVT_W-1:0]  event_code;
    logic [STAT_W-1:0] status;
  } evt_entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    evt_entry_t entry;
  } evt_ctl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [EVT_AW-1:0] fill;
    evt_entry_t        head;
  } evt_stat_t;

endpackage

/* rtl/trhq_area_mem.sv */
// ----------------------------------------------------------------------------
// trhq_area_mem
// area rectangle store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module trhq_area_mem (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [trhq_pkg::AREA_AW-1:0] wr_addr,
  input  trhq_pkg::area_t              wr_data,
  input  logic [trhq_pkg::AREA_AW-1:0] rd_addr,
  output trhq_pkg::area_t              rd_data
);

  trhq_pkg::area_t mem [trhq_pkg::AREA_ENTRIES];
  trhq_pkg::area_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/trhq_level_stack.sv */
// ----------------------------------------------------------------------------
// trhq_level_stack
// stack of levels held in a small memory, top entry read back every cycle
// ----------------------------------------------------------------------------
module trhq_level_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  trhq_pkg::lvl_ctl_t  ctl,
  output trhq_pkg::lvl_stat_t stat
);

  trhq_pkg::lvl_entry_t        mem [trhq_pkg::LEVEL_SLOTS];
  trhq_pkg::lvl_entry_t        top_entry_r;
  logic [trhq_pkg::LVL_TW-1:0] top_r;
  logic [trhq_pkg::LVL_TW-1:0] top_nxt;
  logic [trhq_pkg::LVL_AW-1:0] rd_addr;
  logic [trhq_pkg::LVL_AW-1:0] wr_addr;
  logic                        empty;
  logic                        full;

  assign empty   = (top_r == '0);
  assign full    = (int'(top_r) >= trhq_pkg::LEVEL_SLOTS);
  assign rd_addr = trhq_pkg::LVL_AW'(top_r - 1'b1);
  assign wr_addr = top_r[trhq_pkg::LVL_AW-1:0];

  always_comb begin
    top_nxt = top_r;
    if (ctl.push) begin
      top_nxt = top_r + 1'b1;
    end else if (ctl.pop) begin
      top_nxt = top_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else begin
      top_r <= top_nxt;
    end
  end

  // memory: write at the free slot, read the current top
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_addr] <= ctl.entry;
    end
    top_entry_r <= mem[rd_addr];
  end

  assign stat.empty     = empty;
  assign stat.full      = full;
  assign stat.top_entry = top_entry_r;

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !full)
    else $error("level push while stack full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !empty)
    else $error("level pop while stack empty");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(top_r) <= trhq_pkg::LEVEL_SLOTS)
    else $error("level top beyond stack depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> top_r == $past(top_r) + 1'b1)
    else $error("level push did not advance top");

endmodule

/* rtl/trhq_event_fifo.sv */
// ----------------------------------------------------------------------------
// trhq_event_fifo
// ring queue of events in a memory, one slot always left empty
// ----------------------------------------------------------------------------
module trhq_event_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  trhq_pkg::evt_ctl_t  ctl,
  output trhq_pkg::evt_stat_t stat
);

  trhq_pkg::evt_entry_t        mem [trhq_pkg::EVENT_SLOTS];
  trhq_pkg::evt_entry_t        head_r;
  logic [trhq_pkg::EVT_AW-1:0] wr_ptr_r;
  logic [trhq_pkg::EVT_AW-1:0] wr_ptr_nxt;
  logic [trhq_pkg::EVT_AW-1:0] rd_ptr_r;
  logic [trhq_pkg::EVT_AW-1:0] rd_ptr_nxt;
  logic [trhq_pkg::EVT_AW-1:0] fill;
  logic                        empty;
  logic                        full;

  always_comb begin
    if (wr_ptr_r >= rd_ptr_r) begin
      fill = trhq_pkg::EVT_AW'(wr_ptr_r - rd_ptr_r);
    end else begin
      fill = trhq_pkg::EVT_AW'(trhq_pkg::EVENT_SLOTS + int'(wr_ptr_r) - int'(rd_ptr_r));
    end
  end

  assign empty = (fill == '0);
  assign full  = (int'(fill) == trhq_pkg::EVENT_SLOTS - 1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (ctl.push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == trhq_pkg::EVENT_SLOTS - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (ctl.pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == trhq_pkg::EVENT_SLOTS - 1) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // memory: write at the tail, read the head every cycle
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= ctl.entry;
    end
    head_r <= mem[rd_ptr_r];
  end

  assign stat.empty = empty;
  assign stat.full  = full;
  assign stat.fill  = fill;
  assign stat.head  = head_r;

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !full)
    else $error("event push while queue full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !empty)
    else $error("event pop while queue empty");

  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && !ctl.pop) |=> fill == $past(fill) + 1'b1)
    else $error("event push did not raise fill");

endmodule

/* rtl/touch_region_hit_test_queue.sv */
// ----------------------------------------------------------------------------
// touch_region_hit_test_queue
// touch area store with a level stack, hit test scan and event queue
// ----------------------------------------------------------------------------
// usage
//   one request channel (in_valid / in_stall) carries a command and its
//   fields; every request gives exactly one result on the out_ channel
//   (out_valid / out_stall). commands: write area, push level, pop level,
//   touch, pop event.
//   a touch over a level of n areas tests up to n areas, stopping at the
//   first hit; no scan is run when the stack is empty or the level has no
//   areas. the scan reads one area per cycle from the single read port of
//   the area memory; requests are handled one at a time.
//   in_stall is high while a request is being worked on; a new request is
//   taken as soon as the previous result sits in the output register, even
//   while the receiver still stalls it.
//   a stalled result holds in the output register until taken; the
//   finished next result waits in the sequencer until the slot is free.
//   reset: level stack and event queue come up empty, output is idle; the
//   area store, level entries and event slots hold nothing meaningful
//   until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module touch_region_hit_test_queue (
  input  logic        clk,
  input  logic        rst_n,

  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [5:0]  in_region_index,
  input  logic [6:0]  in_level_count,
  input  logic [9:0]  in_area_x,
  input  logic [9:0]  in_area_y,
  input  logic [9:0]  in_area_w,
  input  logic [9:0]  in_area_h,
  input  logic        in_area_flag,
  input  logic [7:0]  in_area_event,
  input  logic [9:0]  in_touch_x,
  input  logic [9:0]  in_touch_y,
  input  logic [7:0]  in_touch_status,

  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_code,
  output logic        out_hit,
  output logic [5:0]  out_hit_area,
  output logic [7:0]  out_event,
  output logic [7:0]  out_status,
  output logic [3:0]  out_queue_count
);

  // sequencer state
  trhq_pkg::state_t                 state_r;
  trhq_pkg::state_t                 state_nxt;

  // captured request
  logic [trhq_pkg::CMD_W-1:0]       cmd_r;
  logic [trhq_pkg::IDX_W-1:0]       idx_r;
  logic [trhq_pkg::CNT_W-1:0]       cnt_r;
  trhq_pkg::area_t                  area_r;
  logic [trhq_pkg::COORD_W-1:0]     tx_r;
  logic [trhq_pkg::COORD_W-1:0]     ty_r;
  logic [trhq_pkg::STAT_W-1:0]      ts_r;

  // scan position and areas still to test
  logic [trhq_pkg::AREA_AW-1:0]     scan_k_r;
  logic [trhq_pkg::AREA_AW-1:0]     scan_k_nxt;
  logic [trhq_pkg::CNT_W-1:0]       scan_left_r;
  logic [trhq_pkg::CNT_W-1:0]       scan_left_nxt;

  // result being built
  trhq_pkg::res_code_t              res_code_r;
  trhq_pkg::res_code_t              res_code_nxt;
  logic                             res_hit_r;
  logic                             res_hit_nxt;
  logic [trhq_pkg::IDX_W-1:0]       res_area_r;
  logic [trhq_pkg::IDX_W-1:0]       res_area_nxt;
  logic [trhq_pkg::EVT_W-1:0]       res_ev_r;
  logic [trhq_pkg::EVT_W-1:0]       res_ev_nxt;
  logic [trhq_pkg::STAT_W-1:0]      res_st_r;
  logic [trhq_pkg::STAT_W-1:0]      res_st_nxt;

  // output register
  logic                             out_valid_r;
  logic                             out_load;
  logic [trhq_pkg::CODE_W-1:0]      out_code_r;
  logic                             out_hit_r;
  logic [trhq_pkg::IDX_W-1:0]       out_area_r;
  logic [trhq_pkg::EVT_W-1:0]       out_ev_r;
  logic [trhq_pkg::STAT_W-1:0]      out_st_r;
  logic [trhq_pkg::QCNT_W-1:0]      out_qcnt_r;

  // memory side
  logic                             area_we;
  logic [trhq_pkg::AREA_AW-1:0]     area_rd_addr;
  trhq_pkg::area_t                  area_rd_data;
  trhq_pkg::lvl_ctl_t               lvl_ctl;
  trhq_pkg::lvl_stat_t              lvl_stat;
  trhq_pkg::evt_ctl_t               evt_ctl;
  trhq_pkg::evt_stat_t              evt_stat;

  // hit test of the area read back this cycle
  logic                             flag_ok;
  logic                             in_x;
  logic                             in_y;
  logic                             area_match;
  logic                             in_accept;

  assign in_stall  = (state_r != trhq_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // storage units
  // --------------------------------------------------------------------------
  trhq_area_mem u_area_mem (
    .clk     (clk),
    .wr_en   (area_we),
    .wr_addr (idx_r[trhq_pkg::AREA_AW-1:0]),
    .wr_data (area_r),
    .rd_addr (area_rd_addr),
    .rd_data (area_rd_data)
  );

  trhq_level_stack u_level_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lvl_ctl),
    .stat  (lvl_stat)
  );

  trhq_event_fifo u_event_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (evt_ctl),
    .stat  (evt_stat)
  );

  // --------------------------------------------------------------------------
  // request capture; level top and queue head are read during the accept
  // cycle and show up in the execute state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r               <= in_cmd;
      idx_r               <= in_region_index;
      cnt_r               <= in_level_count;
      area_r.x            <= in_area_x;
      area_r.y            <= in_area_y;
      area_r.w            <= in_area_w;
      area_r.h            <= in_area_h;
      area_r.flag         <= in_area_flag;
      area_r.event_code   <= in_area_event;
      tx_r                <= in_touch_x;
      ty_r                <= in_touch_y;
      ts_r                <= in_touch_status;
    end
  end

  // area suits the touch: flagged areas answer status zero only, unflagged areas nonzero status only
  assign flag_ok = (area_rd_data.flag == (ts_r == '0));
  // point inside, right and bottom edges excluded; sums kept one bit wider
  assign in_x = (tx_r >= area_rd_data.x) &&
                ({1'b0, tx_r} < ({1'b0, area_rd_data.x} + {1'b0, area_rd_data.w}));
  assign in_y = (ty_r >= area_rd_data.y) &&
                ({1'b0, ty_r} < ({1'b0, area_rd_data.y} + {1'b0, area_rd_data.h}));
  assign area_match = flag_ok && in_x && in_y;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trhq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_k_r    <= scan_k_nxt;
    scan_left_r <= scan_left_nxt;
    res_code_r  <= res_code_nxt;
    res_hit_r   <= res_hit_nxt;
    res_area_r  <= res_area_nxt;
    res_ev_r    <= res_ev_nxt;
    res_st_r    <= res_st_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    scan_k_nxt        = scan_k_r;
    scan_left_nxt     = scan_left_r;
    res_code_nxt      = res_code_r;
    res_hit_nxt       = res_hit_r;
    res_area_nxt      = res_area_r;
    res_ev_nxt        = res_ev_r;
    res_st_nxt        = res_st_r;
    area_we           = 1'b0;
    area_rd_addr      = scan_k_r;
    lvl_ctl.push      = 1'b0;
    lvl_ctl.pop       = 1'b0;
    lvl_ctl.entry     = '{base: idx_r, size: cnt_r};
    evt_ctl.push      = 1'b0;
    evt_ctl.pop       = 1'b0;
    evt_ctl.entry     = '{event_code: area_rd_data.event_code, status: ts_r};
    out_load          = 1'b0;

    unique case (state_r)
      trhq_pkg::ST_IDLE: begin
        res_code_nxt = trhq_pkg::RES_OK;
        res_hit_nxt  = 1'b0;
        res_area_nxt = '0;
        res_ev_nxt   = '0;
        res_st_nxt   = '0;
        if (in_valid) begin
          state_nxt = trhq_pkg::ST_EXEC;
        end
      end

      trhq_pkg::ST_EXEC: begin
        state_nxt = trhq_pkg::ST_DONE;
        unique case (cmd_r)
          trhq_pkg::CMD_WRITE_AREA: begin
            if (int'(idx_r) >= trhq_pkg::AREA_ENTRIES) begin
              res_code_nxt = trhq_pkg::RES_BAD_RANGE;
            end else begin
              area_we = 1'b1;
            end
          end
          trhq_pkg::CMD_PUSH_LEVEL: begin
            if (int'(idx_r) + int'(cnt_r) > trhq_pkg::AREA_ENTRIES) begin
              res_code_nxt = trhq_pkg::RES_BAD_RANGE;
            end else if (lvl_stat.full) begin
              res_code_nxt = trhq_pkg::RES_STACK_FULL;
            end else begin
              lvl_ctl.push = 1'b1;
            end
          end
          trhq_pkg::CMD_POP_LEVEL: begin
            if (lvl_stat.empty || (lvl_stat.top_entry.base != idx_r)) begin
              res_code_nxt = trhq_pkg::RES_POP_BAD;
            end else begin
              lvl_ctl.pop = 1'b1;
            end
          end
          trhq_pkg::CMD_TOUCH: begin
            if (lvl_stat.empty) begin
              res_code_nxt = trhq_pkg::RES_NO_LEVEL;
            end else if (lvl_stat.top_entry.size != '0) begin
              // start the scan at the level base
              area_rd_addr  = lvl_stat.top_entry.base[trhq_pkg::AREA_AW-1:0];
              scan_k_nxt    = lvl_stat.top_entry.base[trhq_pkg::AREA_AW-1:0];
              scan_left_nxt = lvl_stat.top_entry.size;
              state_nxt     = trhq_pkg::ST_SCAN;
            end
          end
          trhq_pkg::CMD_POP_EVENT: begin
            if (evt_stat.empty) begin
              res_code_nxt = trhq_pkg::RES_QUEUE_EMPTY;
            end else begin
              evt_ctl.pop = 1'b1;
              res_ev_nxt  = evt_stat.head.event_code;
              res_st_nxt  = evt_stat.head.status;
            end
          end
          default: begin
            res_code_nxt = trhq_pkg::RES_BAD_RANGE;
          end
        endcase
      end

      trhq_pkg::ST_SCAN: begin
        // area data of scan_k_r is valid here
        if (area_match) begin
          res_hit_nxt  = 1'b1;
          res_area_nxt = trhq_pkg::IDX_W'(scan_k_r);
          // full queue drops the event silently
          evt_ctl.push = !evt_stat.full;
          state_nxt    = trhq_pkg::ST_DONE;
        end else if (scan_left_r == trhq_pkg::CNT_W'(1)) begin
          state_nxt = trhq_pkg::ST_DONE;
        end else begin
          area_rd_addr  = scan_k_r + 1'b1;
          scan_k_nxt    = scan_k_r + 1'b1;
          scan_left_nxt = scan_left_r - 1'b1;
        end
      end

      trhq_pkg::ST_DONE: begin
        // memory writes of this request have landed, so the next request
        // reads up-to-date stack, queue and area data
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = trhq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = trhq_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r <= res_code_r;
      out_hit_r  <= res_hit_r;
      out_area_r <= res_area_r;
      out_ev_r   <= res_ev_r;
      out_st_r   <= res_st_r;
      // queue pointers already reflect this request
      out_qcnt_r <= evt_stat.fill;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_code = out_code_r;
  assign out_hit         = out_hit_r;
  assign out_hit_area    = out_area_r;
  assign out_event       = out_ev_r;
  assign out_status      = out_st_r;
  assign out_queue_count = out_qcnt_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == trhq_pkg::ST_EXEC)
    else $error("accepted request did not start");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == trhq_pkg::ST_SCAN |->
      (scan_left_r != '0) &&
      (int'(scan_k_r) + int'(scan_left_r) <= trhq_pkg::AREA_ENTRIES))
    else $error("scan outside the level range");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trhq_pkg::ST_DONE && out_valid_r && out_stall) |=>
      state_r == trhq_pkg::ST_DONE && out_valid_r)
    else $error("result overwrote a stalled result");

  a_hit_is_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_hit_r) |-> cmd_r == trhq_pkg::CMD_TOUCH)
    else $error("hit reported for a non-touch request");

endmodule
